/* design/pus_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_pkg
// Shared types, step codes and register defaults of the power-up sequencer.
// ----------------------------------------------------------------------------
package pus_pkg;

    // widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned EN_W     = 8;
    localparam int unsigned CFG_IX_W = 2;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 48;

    // power-up step codes
    localparam logic [STEP_W-1:0] STEP_START     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LIGHT     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PERIPH    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_HASH      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PACK      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PRE_ON    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MOTOR     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_PRE_OFF   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SHUTDOWN  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SWITCH    = 4'd9;

    // enable bit positions
    localparam int unsigned BIT_LIGHT     = 0;
    localparam int unsigned BIT_FRONT     = 1;
    localparam int unsigned BIT_IMU       = 2;
    localparam int unsigned BIT_PACK      = 3;
    localparam int unsigned BIT_PRECHARGE = 4;
    localparam int unsigned BIT_MOTOR     = 5;
    localparam int unsigned BIT_SHUTDOWN  = 6;
    localparam int unsigned BIT_SWITCH    = 7;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_SHORT_DELAY     = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_PRECHARGE_DELAY = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_SWITCH_DELAY    = 2'd2;

    // configuration reset values
    localparam logic [DELAY_W-1:0] SHORT_DELAY_RST     = 16'd50;
    localparam logic [DELAY_W-1:0] PRECHARGE_DELAY_RST = 16'd2000;
    localparam logic [DELAY_W-1:0] SWITCH_DELAY_RST    = 16'd5000;

    typedef struct packed {
        logic [DELAY_W-1:0] short_delay_ms;
        logic [DELAY_W-1:0] precharge_delay_ms;
        logic [DELAY_W-1:0] switch_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [TIME_W-1:0] entry_time;
        logic              just_entered;
        logic              started;
        logic [EN_W-1:0]   enables;
    } t_seq_state;

    typedef struct packed {
        logic              switch_close;
        logic              switch_cmd_seen;
        logic              pack_precharge;
        logic              pack_negative;
        logic              pack_positive;
        logic              contactor_cmd_seen;
        logic              peer_hash_valid;
        logic              peer_status_seen;
        logic [TIME_W-1:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic              hash_sync_send;
        logic [EN_W-1:0]   enables;
        logic [TIME_W-1:0] elapsed_ms;
        logic [STEP_W-1:0] state_code;
    } t_result;

endpackage

/* design/pus_step_logic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_step_logic
// Per-update decision: entry actions, advance condition and result fields.
// ----------------------------------------------------------------------------
module pus_step_logic (
    input  pus_pkg::t_seq_state i_state,
    input  pus_pkg::t_in_item   i_item,
    input  pus_pkg::t_cfg       i_cfg,
    output pus_pkg::t_seq_state o_state,
    output pus_pkg::t_result    o_result
);

    logic [pus_pkg::TIME_W-1:0] w_entry;
    logic [pus_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_entering;
    logic                       w_short_done;
    logic                       w_pre_done;
    logic                       w_switch_done;
    logic                       w_move;
    logic                       w_hash;
    logic [pus_pkg::EN_W-1:0]   w_en;

    // first update acts as entry into the start step
    assign w_entry    = i_state.started ? i_state.entry_time : i_item.time_ms;
    assign w_entering = i_state.started ? i_state.just_entered : 1'b1;
    assign w_elapsed  = i_item.time_ms - w_entry;

    // unsigned timed thresholds, strictly greater
    assign w_short_done  = w_elapsed > {16'd0, i_cfg.short_delay_ms};
    assign w_pre_done    = w_elapsed > {16'd0, i_cfg.precharge_delay_ms};
    assign w_switch_done = w_elapsed > {16'd0, i_cfg.switch_delay_ms};

    // step actions and advance condition
    always_comb begin
        w_en   = i_state.enables;
        w_move = 1'b0;
        w_hash = 1'b0;
        case (i_state.step)
            pus_pkg::STEP_START: begin
                if (w_entering) begin
                    w_en = i_state.enables & (8'd1 << pus_pkg::BIT_SWITCH);
                end
                w_move = w_short_done;
            end
            pus_pkg::STEP_LIGHT: begin
                if (w_entering) begin
                    w_en[pus_pkg::BIT_LIGHT] = 1'b1;
                end
                w_move = w_short_done;
            end
            pus_pkg::STEP_PERIPH: begin
                if (w_entering) begin
                    w_en[pus_pkg::BIT_FRONT] = 1'b1;
                    w_en[pus_pkg::BIT_IMU]   = 1'b1;
                end
                w_move = w_short_done && i_item.peer_status_seen;
            end
            pus_pkg::STEP_HASH: begin
                w_hash = 1'b1;
                w_move = i_item.peer_status_seen && i_item.peer_hash_valid;
            end
            pus_pkg::STEP_PACK: begin
                if (w_entering) begin
                    w_en[pus_pkg::BIT_PACK] = 1'b1;
                end
                w_move = i_item.contactor_cmd_seen && !i_item.pack_positive
                         && !i_item.pack_negative && !i_item.pack_precharge;
            end
            pus_pkg::STEP_PRE_ON: begin
                if (w_entering) begin
                    w_en[pus_pkg::BIT_PRECHARGE] = 1'b1;
                end
                w_move = w_pre_done;
            end
            pus_pkg::STEP_MOTOR: begin
                if (w_entering) begin
                    w_en[pus_pkg::BIT_MOTOR] = 1'b1;
                end
                w_move = w_short_done;
            end
            pus_pkg::STEP_PRE_OFF: begin
                if (w_entering) begin
                    w_en[pus_pkg::BIT_PRECHARGE] = 1'b0;
                end
                w_move = w_short_done;
            end
            pus_pkg::STEP_SHUTDOWN: begin
                if (w_entering) begin
                    w_en[pus_pkg::BIT_SHUTDOWN] = 1'b1;
                end
                w_move = i_item.contactor_cmd_seen && i_item.pack_positive
                         && i_item.pack_negative && !i_item.pack_precharge;
            end
            pus_pkg::STEP_SWITCH: begin
                // drive low each update unless commanded after the delay
                w_en[pus_pkg::BIT_SWITCH] = w_switch_done && i_item.switch_cmd_seen
                                            && i_item.switch_close;
            end
            default: begin
                w_en = i_state.enables;
            end
        endcase
    end

    // next state
    assign o_state.step         = w_move ? i_state.step + 4'd1 : i_state.step;
    assign o_state.entry_time   = w_move ? i_item.time_ms : w_entry;
    assign o_state.just_entered = w_move;
    assign o_state.started      = 1'b1;
    assign o_state.enables      = w_en;

    // result fields
    assign o_result.state_code     = i_state.step;
    assign o_result.elapsed_ms     = w_elapsed;
    assign o_result.enables        = w_en;
    assign o_result.hash_sync_send = w_hash;

endmodule

/* design/power_up_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_up_sequencer
// Low-voltage power-up sequencer with stream input and result channels.
// ----------------------------------------------------------------------------
// Each accepted update yields one result on the result port: the update is
// held in the input register while the step decision works on it, and the
// decision is captured in the result register as the update leaves. A new
// update is taken every cycle while results are taken, since the step state
// is updated by one short decision in the same cycle an update leaves the
// input register. While a result waits, the input register takes one more
// update and then the input stalls until the result transfers. The three
// delay registers are written through the plain write port (index 0 short
// delay, 1 precharge hold, 2 switch delay, index 3 ignored) and should only
// be changed while the block is idle.
module power_up_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // update stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] time_ms, [32] peer_status_seen, [33] peer_hash_valid,
    // [34] contactor_cmd_seen, [35] pack_positive, [36] pack_negative,
    // [37] pack_precharge, [38] switch_cmd_seen, [39] switch_close
    input  logic [39:0] i_s_tdata,
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] state_code, [35:4] elapsed_ms, [36] light_enable,
    // [37] front_ctrl_enable, [38] imu_enable, [39] pack_enable,
    // [40] precharge_enable, [41] motor_ctrl_enable,
    // [42] shutdown_loop_enable, [43] motor_switch_enable,
    // [44] hash_sync_send, [47:45] zero
    output logic [47:0] o_m_tdata
);

    pus_pkg::t_cfg       r_cfg;
    pus_pkg::t_seq_state r_state;
    pus_pkg::t_seq_state n_state;
    pus_pkg::t_in_item   r_item;
    pus_pkg::t_result    n_result;
    pus_pkg::t_result    r_result;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                w_adv;
    logic                w_proc;
    logic                w_take;

    // pipeline handshakes
    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_take     = i_s_tvalid && o_s_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_delay_ms     <= pus_pkg::SHORT_DELAY_RST;
            r_cfg.precharge_delay_ms <= pus_pkg::PRECHARGE_DELAY_RST;
            r_cfg.switch_delay_ms    <= pus_pkg::SWITCH_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pus_pkg::CFG_SHORT_DELAY:     r_cfg.short_delay_ms     <= i_cfg_data;
                pus_pkg::CFG_PRECHARGE_DELAY: r_cfg.precharge_delay_ms <= i_cfg_data;
                pus_pkg::CFG_SWITCH_DELAY:    r_cfg.switch_delay_ms    <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= pus_pkg::t_in_item'(i_s_tdata);
        end
    end

    // step decision
    pus_step_logic u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.step         <= pus_pkg::STEP_START;
            r_state.entry_time   <= '0;
            r_state.just_entered <= 1'b1;
            r_state.started      <= 1'b0;
            r_state.enables      <= '0;
        end else if (w_proc) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_result};

`ifndef SYNTHESIS
    // the step never passes the motor switch step
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.step <= pus_pkg::STEP_SWITCH)
        else $error("step code beyond motor switch step");

    // hash sync only reported from the check hash step
    a_hash_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.hash_sync_send
                         == (r_result.state_code == pus_pkg::STEP_HASH)))
        else $error("hash sync flag does not match reported step");

    // an advance marks the next update as an entry
    a_entry_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (n_state.step != r_state.step)) |=> r_state.just_entered)
        else $error("step advanced without entry mark");

    // a processed update always leaves the sequencer started
    a_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> r_state.started)
        else $error("sequencer not started after an update");
`endif

endmodule
